FILE: hw/rtl/bde_pkg.sv
// shared types and constants for the 9x9 binary dilate/erode block
package bde_pkg;

    // pixel and flag types
    typedef logic [7:0]  t_pixel;
    typedef logic [1:0]  t_flags;
    typedef logic [11:0] t_row;
    typedef logic [10:0] t_col_out;
    typedef logic [11:0] t_cfg_data;
    typedef logic [1:0]  t_cfg_index;

    // flag bits kept per pixel
    localparam int FLAG_ZERO_BIT = 0;
    localparam int FLAG_FULL_BIT = 1;

    localparam t_pixel PIX_ZERO = 8'd0;
    localparam t_pixel PIX_FULL = 8'd255;

    // register indexes of the configuration channel
    localparam t_cfg_index REG_IMAGE_WIDTH  = 2'd0;
    localparam t_cfg_index REG_IMAGE_HEIGHT = 2'd1;
    localparam t_cfg_index REG_ERODE_MODE   = 2'd2;

    // reset values of the registers
    localparam t_cfg_data RST_IMAGE_WIDTH  = 12'd640;
    localparam t_cfg_data RST_IMAGE_HEIGHT = 12'd480;

    // width used for size compares, wide enough for 4096
    localparam int CMP_W      = 13;
    localparam int MAX_HEIGHT = 4095;

    // control of one line buffer cell
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_lb_ctrl;

endpackage

FILE: hw/rtl/bde_if.sv
// channel interfaces: pixel input, result output, configuration write
interface bde_pix_if;
    import bde_pkg::*;
    logic   valid;
    logic   ready;
    t_pixel pixel;
    modport source(output valid, output pixel, input ready);
    modport sink(input valid, input pixel, output ready);
endinterface

interface bde_res_if;
    import bde_pkg::*;
    logic     valid;
    logic     ready;
    t_pixel   out_pixel;
    t_row     center_row;
    t_col_out center_col;
    logic     frame_last;
    modport source(output valid, output out_pixel, output center_row,
                   output center_col, output frame_last, input ready);
    modport sink(input valid, input out_pixel, input center_row,
                 input center_col, input frame_last, output ready);
endinterface

interface bde_cfg_if;
    import bde_pkg::*;
    logic       valid;
    logic       ready;
    t_cfg_index index;
    t_cfg_data  data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/binary_dilate_erode_9x9_top.sv
// top level of the binary dilate/erode block with a square window
// a pixel's result passes through the stage 1 registers and then the output register
// throughput: one pixel per cycle while the result output is not stalled
// reset: sizes to 640 x 480, dilate mode, row and column counters to zero
// reset: line buffer contents are not cleared, window columns are cleared
module binary_dilate_erode_9x9_top #(
    parameter int WINDOW    = 9,
    parameter int MAX_WIDTH = 2048
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bde_cfg_if.sink   i_cfg,
    bde_pix_if.sink   i_pix,
    bde_res_if.source o_res
);
    import bde_pkg::*;

    localparam int CNT_W = $clog2(MAX_WIDTH);
    localparam int HALF  = (WINDOW - 1) / 2;
    localparam int NLINE = WINDOW - 1;

    // configuration registers
    t_cfg_data r_image_width;
    t_cfg_data r_image_height;
    logic      r_erode_mode;

    // raster position of the next pixel
    logic [CNT_W-1:0] r_col;
    t_row             r_row;

    // stage 1: pixel whose line buffer reads are in flight
    logic             r_s1_valid;
    t_flags           r_s1_cur;
    logic [CNT_W-1:0] r_s1_col;
    t_row             r_s1_row;
    logic             r_s1_interior;
    logic             r_s1_last;

    // output register
    logic     r_o_valid;
    t_pixel   r_o_pixel;
    t_row     r_o_row;
    t_col_out r_o_col;
    logic     r_o_last;

    logic             pix_acc;
    logic             s1_adv;
    logic [CMP_W-1:0] w_clamp;
    logic [CMP_W-1:0] h_clamp;
    logic             end_row;
    logic             end_frame;
    t_flags           cur;
    t_lb_ctrl         lb_ctrl;
    t_flags           lb_rd  [NLINE];
    t_flags           lb_acc [NLINE+1];
    t_flags           win_q  [NLINE];
    t_flags           win_acc[NLINE+1];
    t_flags           colsum;
    t_flags           acc;
    t_pixel           res_pixel;

    // configuration writes, unknown indexes are ignored
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_erode_mode   <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg.data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg.data;
                REG_ERODE_MODE:   r_erode_mode   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // sizes clamped into the supported range
    always_comb begin
        if (CMP_W'(r_image_width) < CMP_W'(WINDOW)) begin
            w_clamp = CMP_W'(WINDOW);
        end else if (CMP_W'(r_image_width) > CMP_W'(MAX_WIDTH)) begin
            w_clamp = CMP_W'(MAX_WIDTH);
        end else begin
            w_clamp = CMP_W'(r_image_width);
        end
        if (CMP_W'(r_image_height) < CMP_W'(WINDOW)) begin
            h_clamp = CMP_W'(WINDOW);
        end else if (CMP_W'(r_image_height) > CMP_W'(MAX_HEIGHT)) begin
            h_clamp = CMP_W'(MAX_HEIGHT);
        end else begin
            h_clamp = CMP_W'(r_image_height);
        end
    end

    // a counter at or past a newly written size also ends its row or frame
    assign end_row   = (CMP_W'(r_col) + CMP_W'(1)) >= w_clamp;
    assign end_frame = end_row && ((CMP_W'(r_row) + CMP_W'(1)) >= h_clamp);

    // stage 1 moves on when the output register is free or being emptied
    assign s1_adv      = r_s1_valid && (!r_o_valid || o_res.ready);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign pix_acc     = i_pix.valid && i_pix.ready;

    // flags of the incoming pixel
    always_comb begin
        cur                = '0;
        cur[FLAG_ZERO_BIT] = (i_pix.pixel == PIX_ZERO);
        cur[FLAG_FULL_BIT] = (i_pix.pixel == PIX_FULL);
    end

    // raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (pix_acc) begin
            if (end_row) begin
                r_col <= '0;
                r_row <= end_frame ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (pix_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_cur      <= cur;
            r_s1_col      <= r_col;
            r_s1_row      <= r_row;
            r_s1_interior <= (r_row >= t_row'(WINDOW - 1))
                          && (CMP_W'(r_col) >= CMP_W'(WINDOW - 1));
            r_s1_last     <= end_frame;
        end
    end

    // line buffer chain: read at the new pixel's column on its transaction,
    // each cell takes over the entry of the cell above one step later;
    // the column after a write is never the one read in the same cycle
    assign lb_ctrl.rd_en = pix_acc;
    assign lb_ctrl.wr_en = s1_adv;
    assign lb_acc[0]     = r_s1_cur;

    for (genvar k = 0; k < NLINE; k++) begin : g_line
        t_flags wr_data;
        if (k < NLINE - 1) begin : g_mid
            assign wr_data = lb_rd[k+1];
        end else begin : g_top
            assign wr_data = r_s1_cur;
        end
        bde_line_cell #(
            .DEPTH(MAX_WIDTH)
        ) u_line (
            .i_clk    (i_clk),
            .i_ctrl   (lb_ctrl),
            .i_rd_addr(r_col),
            .i_wr_addr(r_s1_col),
            .i_wr_data(wr_data),
            .i_acc    (lb_acc[k]),
            .o_rd_data(lb_rd[k]),
            .o_acc    (lb_acc[k+1])
        );
    end

    // OR over the column of the window
    assign colsum     = lb_acc[NLINE];
    assign win_acc[0] = colsum;

    // window chain: newest column summary enters cell 0, the oldest drops off
    for (genvar k = 0; k < NLINE; k++) begin : g_win
        t_flags d;
        if (k == 0) begin : g_first
            assign d = colsum;
        end else begin : g_next
            assign d = win_q[k-1];
        end
        bde_win_cell u_win (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (s1_adv),
            .i_d    (d),
            .i_acc  (win_acc[k]),
            .o_q    (win_q[k]),
            .o_acc  (win_acc[k+1])
        );
    end

    assign acc = win_acc[NLINE];

    // dilate: black if any pixel is 0; erode: white if any pixel is 255
    always_comb begin
        if (r_erode_mode) begin
            res_pixel = acc[FLAG_FULL_BIT] ? PIX_FULL : PIX_ZERO;
        end else begin
            res_pixel = acc[FLAG_ZERO_BIT] ? PIX_ZERO : PIX_FULL;
        end
    end

    // output register, loaded only for interior centres
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv && r_s1_interior) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_interior) begin
            r_o_pixel <= res_pixel;
            r_o_row   <= r_s1_row - t_row'(HALF);
            r_o_col   <= t_col_out'(r_s1_col - CNT_W'(HALF));
            r_o_last  <= r_s1_last;
        end
    end

    assign o_res.valid      = r_o_valid;
    assign o_res.out_pixel  = r_o_pixel;
    assign o_res.center_row = r_o_row;
    assign o_res.center_col = r_o_col;
    assign o_res.frame_last = r_o_last;

endmodule

FILE: hw/rtl/bde_line_cell.sv
// line buffer cell: one row of flag pairs, hands its old entry to the next cell
module bde_line_cell #(
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  bde_pkg::t_lb_ctrl i_ctrl,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic [AW-1:0]     i_wr_addr,
    input  bde_pkg::t_flags   i_wr_data,
    input  bde_pkg::t_flags   i_acc,
    output bde_pkg::t_flags   o_rd_data,
    output bde_pkg::t_flags   o_acc
);
    import bde_pkg::*;

    t_flags r_mem [DEPTH];
    t_flags r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    // column summary grows by this row's flags
    assign o_acc     = i_acc | r_rd_data;

endmodule

FILE: hw/rtl/bde_win_cell.sv
// window cell: one column summary, shifted to the neighbor on each step
module bde_win_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  bde_pkg::t_flags i_d,
    input  bde_pkg::t_flags i_acc,
    output bde_pkg::t_flags o_q,
    output bde_pkg::t_flags o_acc
);
    import bde_pkg::*;

    t_flags r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q   = r_q;
    assign o_acc = i_acc | r_q;

endmodule

FILE: tb/bde_morph_checker.sv
`timescale 1ns / 1ps
// result checker for the 9x9 dilate/erode block: shadow window model and in-order compare
module bde_morph_checker #(
    parameter int WIN_SIZE = 9,
    parameter int LINE_LEN = 2048
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bde_cfg_if   i_cfg,
    bde_pix_if   i_pix,
    bde_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    import bde_pkg::*;

    localparam int HALF = (WIN_SIZE - 1) / 2;

    typedef struct packed {
        t_pixel   out_pixel;
        t_row     center_row;
        t_col_out center_col;
        logic     frame_last;
    } t_morph_result;

    t_flags        line_flags [WIN_SIZE-1][LINE_LEN];
    t_flags        win_cols [WIN_SIZE];
    int            row_cnt;
    int            col_cnt;
    t_cfg_data     reg_width;
    t_cfg_data     reg_height;
    logic          reg_erode;
    t_morph_result morph_q [$];
    int            fails   = 0;
    int            checked = 0;

    function automatic int clamp_size(input int value, input int lo, input int hi);
        if (value < lo) return lo;
        if (value > hi) return hi;
        return value;
    endfunction

    task automatic reset_shadow;
        foreach (win_cols[k]) win_cols[k] = '0;
        row_cnt    = 0;
        col_cnt    = 0;
        reg_width  = RST_IMAGE_WIDTH;
        reg_height = RST_IMAGE_HEIGHT;
        reg_erode  = 1'b0;
        morph_q.delete();
    endtask

    task automatic write_register(input t_cfg_index idx, input t_cfg_data value);
        case (idx)
            REG_IMAGE_WIDTH:  reg_width  = value;
            REG_IMAGE_HEIGHT: reg_height = value;
            REG_ERODE_MODE:   reg_erode  = value[0];
            default: ;
        endcase
    endtask

    // one pixel through the line buffers and the window, expected result queued for interior centres
    task automatic morph_step(input t_pixel px);
        t_flags        cur;
        t_flags        colsum;
        t_flags        acc;
        int            eff_w;
        int            eff_h;
        logic          end_row;
        logic          end_frame;
        t_morph_result res;
        eff_w     = clamp_size(int'(reg_width), WIN_SIZE, LINE_LEN);
        eff_h     = clamp_size(int'(reg_height), WIN_SIZE, MAX_HEIGHT);
        cur       = '0;
        cur[FLAG_ZERO_BIT] = (px == PIX_ZERO);
        cur[FLAG_FULL_BIT] = (px == PIX_FULL);
        end_row   = (col_cnt + 1 >= eff_w);
        end_frame = end_row && (row_cnt + 1 >= eff_h);

        colsum = cur;
        for (int k = 0; k < WIN_SIZE - 1; k++) colsum |= line_flags[k][col_cnt];
        for (int k = 0; k < WIN_SIZE - 2; k++) line_flags[k][col_cnt] = line_flags[k+1][col_cnt];
        line_flags[WIN_SIZE-2][col_cnt] = cur;
        for (int k = 0; k < WIN_SIZE - 1; k++) win_cols[k] = win_cols[k+1];
        win_cols[WIN_SIZE-1] = colsum;

        if (row_cnt >= WIN_SIZE - 1 && col_cnt >= WIN_SIZE - 1) begin
            acc = '0;
            foreach (win_cols[k]) acc |= win_cols[k];
            if (reg_erode)
                res.out_pixel = acc[FLAG_FULL_BIT] ? PIX_FULL : PIX_ZERO;
            else
                res.out_pixel = acc[FLAG_ZERO_BIT] ? PIX_ZERO : PIX_FULL;
            res.center_row = t_row'(row_cnt - HALF);
            res.center_col = t_col_out'(col_cnt - HALF);
            res.frame_last = end_frame;
            morph_q.push_back(res);
        end

        if (end_row) begin
            col_cnt = 0;
            row_cnt = end_frame ? 0 : row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    task automatic compare_result;
        t_morph_result want;
        if (morph_q.size() == 0) begin
            fails++;
            $display("%0t: result with nothing expected, expected none actual px %0d at %0d,%0d",
                     $time, i_res.out_pixel, i_res.center_row, i_res.center_col);
        end else begin
            want = morph_q.pop_front();
            checked++;
            check_field("out_pixel", want.out_pixel, i_res.out_pixel);
            check_field("center_row", want.center_row, i_res.center_row);
            check_field("center_col", want.center_col, i_res.center_col);
            check_field("frame_last", want.frame_last, i_res.frame_last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_shadow();
        end else begin
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) compare_result();
            if (i_cfg.valid === 1'b1 && i_cfg.ready === 1'b1)
                write_register(i_cfg.index, i_cfg.data);
            if (i_pix.valid === 1'b1 && i_pix.ready === 1'b1) morph_step(i_pix.pixel);
        end
        o_fail_count <= fails;
        o_pending    <= morph_q.size();
        o_checked    <= checked;
    end

endmodule

FILE: tb/tb_binary_dilate_erode_9x9_top.sv
`timescale 1ns / 1ps
// testbench top for the 9x9 dilate/erode block: stimulus, flow control and verdict
module tb_binary_dilate_erode_9x9_top;
    import bde_pkg::*;

    localparam int WIN_SIZE      = 9;
    localparam int LINE_LEN      = 2048;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 7;
    // leave margin after the last result so the pipe drains before touching registers
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 150;
    localparam int DIRECTED_LEN  = 25;
    localparam int WIDE_TAIL     = 30;
    localparam int NARROW_WIDTH  = 10;
    localparam int SMALL_MAX_W   = 24;
    localparam int SMALL_MAX_H   = 12;
    // index 3 is not a register, writes to it must be dropped
    localparam t_cfg_index REG_UNUSED   = 2'd3;
    localparam t_cfg_data  CFG_ALL_ONES = 12'hFFF;

    logic i_clk;
    logic i_rst_n;

    bde_cfg_if cfg_ch ();
    bde_pix_if pix_ch ();
    bde_res_if res_ch ();

    int fail_count;
    int pending_count;
    int result_count;

    // flow control knobs, percent of cycles spent idle
    int tx_idle_pct;
    int rx_idle_pct;

    // receiver hold-off, requested by a toggle from the stimulus process
    logic hold_toggle;
    logic hold_seen;
    int   hold_left;

    // raster position and sizes in use, tracked so width only grows at a frame start
    int used_w;
    int used_h;
    int pos_row;
    int pos_col;
    int pixels_sent;
    int cycle_count;

    t_pixel directed_px [DIRECTED_LEN];

    binary_dilate_erode_9x9_top #(
        .WINDOW    (WIN_SIZE),
        .MAX_WIDTH (LINE_LEN)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    bde_morph_checker #(
        .WIN_SIZE (WIN_SIZE),
        .LINE_LEN (LINE_LEN)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_ch),
        .i_pix        (pix_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (result_count)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // result side: random ready, or held low for a long stretch on request
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen    <= hold_toggle;
            hold_left    <= HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped by watchdog after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // size as the block uses it, clamped to what the window and line buffers allow
    function automatic int fit_size(input t_cfg_data value, input int hi);
        if (value < WIN_SIZE) return WIN_SIZE;
        if (value > hi) return hi;
        return value;
    endfunction

    // grey pixel with extra weight on the two values that set flags
    function automatic t_pixel pick_pixel(input int zero_pct, input int full_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < zero_pct) return PIX_ZERO;
        if (roll < zero_pct + full_pct) return PIX_FULL;
        return t_pixel'($urandom_range(0, 255));
    endfunction

    // one register write transaction, followed by a bubble so valid drops cleanly
    task automatic cfg_write(input t_cfg_index idx, input t_cfg_data value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  used_w = fit_size(value, LINE_LEN);
            REG_IMAGE_HEIGHT: used_h = fit_size(value, MAX_HEIGHT);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // one pixel transaction, with random idle cycles ahead of it
    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= px;
        do @(posedge i_clk); while (pix_ch.ready !== 1'b1);
        pixels_sent++;
        // a counter already past a shrunk size ends its row or frame here
        if (pos_col + 1 >= used_w) begin
            pos_col = 0;
            pos_row = (pos_row + 1 >= used_h) ? 0 : pos_row + 1;
        end else begin
            pos_col++;
        end
    endtask

    // keep sending until the raster wraps back to the top left corner
    task automatic finish_frame(input int zero_pct, input int full_pct);
        do send_pixel(pick_pixel(zero_pct, full_pct));
        while (pos_row != 0 || pos_col != 0);
    endtask

    // stop the input, wait for every outstanding result, then let the pipe drain
    task automatic settle;
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random frames; some get new sizes, some are cut short inside the frame
    task automatic run_phase(input int budget);
        int stop_at;
        int zero_pct;
        int full_pct;
        int cut;
        stop_at = pixels_sent + budget;
        while (pixels_sent < stop_at) begin
            zero_pct = $urandom_range(0, 3);
            full_pct = $urandom_range(0, 3);
            // frames back to back share a geometry, otherwise reprogram at the frame start
            if ($urandom_range(0, 1) == 1) begin
                settle();
                cfg_write(REG_IMAGE_WIDTH, t_cfg_data'(($urandom_range(0, 7) == 0)
                          ? $urandom_range(0, WIN_SIZE - 1)
                          : $urandom_range(WIN_SIZE, SMALL_MAX_W)));
                cfg_write(REG_IMAGE_HEIGHT, t_cfg_data'(($urandom_range(0, 7) == 0)
                          ? $urandom_range(0, WIN_SIZE - 1)
                          : $urandom_range(WIN_SIZE, SMALL_MAX_H)));
                cfg_write(REG_ERODE_MODE, t_cfg_data'($urandom_range(0, 4095)));
            end
            if ($urandom_range(0, 3) == 0) begin
                // pause mid-frame, then shrink a size so the counters overrun it;
                // the width never grows here, so no unwritten line buffer entry is read
                cut = $urandom_range(1, used_w * used_h - 1);
                repeat (cut) send_pixel(pick_pixel(zero_pct, full_pct));
                settle();
                if ($urandom_range(0, 1) == 1)
                    cfg_write(REG_IMAGE_WIDTH, t_cfg_data'($urandom_range(0, used_w)));
                else
                    cfg_write(REG_IMAGE_HEIGHT, t_cfg_data'($urandom_range(0, pos_row)));
            end
            finish_frame(zero_pct, full_pct);
        end
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_IMAGE_WIDTH;
        cfg_ch.data  = '0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        res_ch.ready = 1'b0;
        hold_toggle  = 1'b0;
        hold_seen    = 1'b0;
        hold_left    = 0;
        cycle_count  = 0;
        pixels_sent  = 0;
        used_w       = RST_IMAGE_WIDTH;
        used_h       = RST_IMAGE_HEIGHT;
        pos_row      = 0;
        pos_col      = 0;
        tx_idle_pct  = 11;
        rx_idle_pct  = 88;
        // extremes and neighbors of the two flag values, then a few bit patterns
        directed_px  = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd127, 8'd128, 8'd85, 8'd170,
                         8'd0, 8'd0, 8'd255, 8'd255, 8'd2, 8'd253, 8'd64, 8'd192,
                         8'd0, 8'd255, 8'd16, 8'd32, 8'd8, 8'd4, 8'd240, 8'd251, 8'd0};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed start: dropped register index, both sizes below the window
        // (clamped to 9x9), dilate mode
        cfg_write(REG_UNUSED, CFG_ALL_ONES);
        cfg_write(REG_IMAGE_WIDTH, '0);
        cfg_write(REG_IMAGE_HEIGHT, '0);
        cfg_write(REG_ERODE_MODE, '0);
        foreach (directed_px[i]) send_pixel(directed_px[i]);
        finish_frame(2, 2);
        // erode mode, selected with every data bit set
        settle();
        cfg_write(REG_ERODE_MODE, CFG_ALL_ONES);
        finish_frame(2, 2);

        // sender mostly busy, receiver mostly stalled
        run_phase(PHASE_ITEMS);

        // sender mostly idle, receiver mostly ready
        tx_idle_pct = 88;
        rx_idle_pct = 11;
        run_phase(PHASE_ITEMS);

        // full rate on both sides, with one long receiver stall that backs up the input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        settle();
        cfg_write(REG_IMAGE_WIDTH, t_cfg_data'(SMALL_MAX_W));
        cfg_write(REG_IMAGE_HEIGHT, t_cfg_data'(SMALL_MAX_H));
        hold_toggle <= ~hold_toggle;
        finish_frame(1, 1);
        run_phase(PHASE_ITEMS);

        // largest sizes: part of a row at width 2048 and height 4095, then both sizes
        // shrink under the counters so the row and then the frame end early
        settle();
        cfg_write(REG_IMAGE_WIDTH, CFG_ALL_ONES);
        cfg_write(REG_IMAGE_HEIGHT, CFG_ALL_ONES);
        cfg_write(REG_ERODE_MODE, t_cfg_data'($urandom_range(0, 4095)));
        repeat (WIDE_TAIL) send_pixel(pick_pixel(1, 1));
        settle();
        cfg_write(REG_IMAGE_WIDTH, t_cfg_data'(NARROW_WIDTH));
        while (pos_row < WIN_SIZE + 3) send_pixel(pick_pixel(1, 1));
        settle();
        cfg_write(REG_IMAGE_HEIGHT, t_cfg_data'(WIN_SIZE / 3));
        finish_frame(1, 1);

        settle();
        $display("covered %0d pixels and %0d checked results, dilate and erode, sizes clamped",
                 pixels_sent, result_count);
        $display("below 9x9 and above 2048x4095, with rows and frames cut short mid-stream");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
